// File: hw/rtl/dda_pkg.sv
// ============================================================================
// dda_pkg
// Shared types and constants of the DDA line rasterizer.
// ============================================================================
package dda_pkg;

   localparam int COORD_IN_W = 8;   // input coordinate width, two's complement
   localparam int COORD_W    = 9;   // internal signed coordinate / delta width
   localparam int LEN_W      = 8;   // major-axis length, 0..255
   localparam int RES_W      = 10;  // signed remainder plus one step
   localparam int PIX_W      = 6;   // output pixel coordinate width
   localparam int COLOR_W    = 32;

   localparam int CLIP_MAX_DEFAULT    = 63;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified line, as handed from the front end to the walker.
   typedef struct packed {
      logic signed [COORD_W-1:0] major0;   // start on the major axis
      logic signed [COORD_W-1:0] minor0;   // start on the minor axis
      logic signed [COORD_W-1:0] minor_d;  // minor-axis delta
      logic [LEN_W-1:0]          len;      // |major delta|, also the denominator
      logic                      dir_neg;  // major axis walks downward
      logic                      xmajor;   // horizontal axis is major
      logic [COLOR_W-1:0]        color;
   } dda_line_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_RUN,
      WALK_FLUSH
   } dda_state_type;

   typedef struct packed {
      logic idle;
      logic pend_valid;
   } dda_walk_status_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [4:0] count;
   } dda_queue_status_type;

endpackage

// File: hw/rtl/dda_front.sv
// ============================================================================
// dda_front
// Accept line items, classify major axis, length and direction, and push
// a descriptor into the line queue. Drop zero-length lines.
// ============================================================================
module dda_front (
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dda_pkg::COORD_IN_W-1:0]  req_start_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0]  req_start_y,
   input  logic signed [dda_pkg::COORD_IN_W-1:0]  req_end_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0]  req_end_y,
   input  logic [dda_pkg::COLOR_W-1:0]            req_pen_color,
   input  logic                                   queue_full,
   output logic                                   push,
   output dda_pkg::dda_line_type                  push_data
);

   logic signed [dda_pkg::COORD_W-1:0] x0, y0, x1, y1;
   logic signed [dda_pkg::COORD_W-1:0] dx, dy;
   logic [dda_pkg::COORD_W-1:0]        adx, ady;
   logic                               xmajor;

   always_comb begin
      x0 = {req_start_x[dda_pkg::COORD_IN_W-1], req_start_x};
      y0 = {req_start_y[dda_pkg::COORD_IN_W-1], req_start_y};
      x1 = {req_end_x[dda_pkg::COORD_IN_W-1], req_end_x};
      y1 = {req_end_y[dda_pkg::COORD_IN_W-1], req_end_y};
      dx = x1 - x0;
      dy = y1 - y0;
      adx = dx[dda_pkg::COORD_W-1] ? $unsigned(-dx) : $unsigned(dx);
      ady = dy[dda_pkg::COORD_W-1] ? $unsigned(-dy) : $unsigned(dy);
      xmajor = (adx >= ady);

      push_data.major0  = xmajor ? x0 : y0;
      push_data.minor0  = xmajor ? y0 : x0;
      push_data.minor_d = xmajor ? dy : dx;
      push_data.len     = xmajor ? adx[dda_pkg::LEN_W-1:0] : ady[dda_pkg::LEN_W-1:0];
      push_data.dir_neg = xmajor ? dx[dda_pkg::COORD_W-1] : dy[dda_pkg::COORD_W-1];
      push_data.xmajor  = xmajor;
      push_data.color   = req_pen_color;
   end

   assign req_ready = !queue_full;
   // a zero-length line produces no pixel: accept it and drop it here
   assign push = req_valid && !queue_full && (push_data.len != '0);

endmodule

// File: hw/rtl/dda_queue.sv
// ============================================================================
// dda_queue
// Short FIFO of classified lines between the front end and the walker.
// ============================================================================
module dda_queue #(
   parameter int DEPTH = dda_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  dda_pkg::dda_line_type         push_data,
   input  logic                          pop,
   output dda_pkg::dda_line_type         pop_data,
   output dda_pkg::dda_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dda_pkg::dda_line_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push   = push && (count_ff != CNT_W'(DEPTH));
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = 5'(count_ff);

endmodule

// File: hw/rtl/dda_walk.sv
// ============================================================================
// dda_walk
// Step one line along its major axis with an exact remainder accumulator,
// clip each pixel, and hold one pixel back so the last one can be flagged.
// ============================================================================
module dda_walk #(
   parameter int CLIP_MAX = dda_pkg::CLIP_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              line_valid,
   input  dda_pkg::dda_line_type             line_data,
   output logic                              line_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dda_pkg::PIX_W-1:0]         rsp_pixel_x,
   output logic [dda_pkg::PIX_W-1:0]         rsp_pixel_y,
   output logic [dda_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic                              rsp_last_pixel,
   output dda_pkg::dda_walk_status_type      status
);

   localparam int CW = dda_pkg::COORD_W;
   localparam int RW = dda_pkg::RES_W;
   localparam int LW = dda_pkg::LEN_W;
   localparam int PW = dda_pkg::PIX_W;
   localparam logic [CW-1:0] CLIP_LIM = CW'(CLIP_MAX);

   dda_pkg::dda_state_type state_ff, state_in;

   logic signed [CW-1:0] major_ff, major_in;
   logic signed [CW-1:0] quo_ff, quo_in;
   logic signed [RW-1:0] res_ff, res_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic signed [CW-1:0] dm_ff, dm_in;
   logic [LW-1:0]        den_ff, den_in;
   logic                 dir_neg_ff, dir_neg_in;
   logic                 xmajor_ff, xmajor_in;
   logic [dda_pkg::COLOR_W-1:0] color_ff, color_in;

   logic          pend_valid_ff, pend_valid_in;
   logic [PW-1:0] pend_x_ff, pend_x_in;
   logic [PW-1:0] pend_y_ff, pend_y_in;

   logic          out_valid_ff, out_valid_in;
   logic [PW-1:0] out_x_ff, out_x_in;
   logic [PW-1:0] out_y_ff, out_y_in;
   logic [dda_pkg::COLOR_W-1:0] out_color_ff, out_color_in;
   logic          out_last_ff, out_last_in;

   logic signed [CW-1:0] minor_cur, px_cur, py_cur;
   logic signed [RW-1:0] res_sum, den_ext;
   logic                 in_clip, out_free, need_out;

   always_comb begin
      // floor quotient plus remainder gives truncation toward zero
      minor_cur = quo_ff + ((quo_ff[CW-1] && (res_ff != '0)) ? CW'(1) : CW'(0));
      px_cur    = xmajor_ff ? major_ff : minor_cur;
      py_cur    = xmajor_ff ? minor_cur : major_ff;
      in_clip   = !px_cur[CW-1] && !py_cur[CW-1] &&
                  ($unsigned(px_cur) <= CLIP_LIM) && ($unsigned(py_cur) <= CLIP_LIM);
      out_free  = !out_valid_ff || rsp_ready;
      need_out  = in_clip && pend_valid_ff;
      res_sum   = res_ff + {dm_ff[CW-1], dm_ff};
      den_ext   = $signed({{(RW-LW){1'b0}}, den_ff});

      state_in      = state_ff;
      major_in      = major_ff;
      quo_in        = quo_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      dm_in         = dm_ff;
      den_in        = den_ff;
      dir_neg_in    = dir_neg_ff;
      xmajor_in     = xmajor_ff;
      color_in      = color_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;
      line_pop      = 1'b0;

      unique case (state_ff)
         dda_pkg::WALK_IDLE: begin
            if (line_valid) begin
               line_pop   = 1'b1;
               major_in   = line_data.major0;
               quo_in     = line_data.minor0;
               res_in     = '0;
               cnt_in     = line_data.len;
               dm_in      = line_data.minor_d;
               den_in     = line_data.len;
               dir_neg_in = line_data.dir_neg;
               xmajor_in  = line_data.xmajor;
               color_in   = line_data.color;
               state_in   = dda_pkg::WALK_RUN;
            end
         end
         dda_pkg::WALK_RUN: begin
            // hold the walk while a held pixel cannot move to the output
            if (!need_out || out_free) begin
               if (need_out) begin
                  out_valid_in = 1'b1;
                  out_x_in     = pend_x_ff;
                  out_y_in     = pend_y_ff;
                  out_color_in = color_ff;
                  out_last_in  = 1'b0;
               end
               if (in_clip) begin
                  pend_valid_in = 1'b1;
                  pend_x_in     = px_cur[PW-1:0];
                  pend_y_in     = py_cur[PW-1:0];
               end
               major_in = dir_neg_ff ? major_ff - CW'(1) : major_ff + CW'(1);
               if (res_sum >= den_ext) begin
                  res_in = res_sum - den_ext;
                  quo_in = quo_ff + CW'(1);
               end else if (res_sum[RW-1]) begin
                  res_in = res_sum + den_ext;
                  quo_in = quo_ff - CW'(1);
               end else begin
                  res_in = res_sum;
               end
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == LW'(1)) begin
                  state_in = dda_pkg::WALK_FLUSH;
               end
            end
         end
         dda_pkg::WALK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = dda_pkg::WALK_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = pend_x_ff;
               out_y_in      = pend_y_ff;
               out_color_in  = color_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = dda_pkg::WALK_IDLE;
            end
         end
         default: begin
            state_in = dda_pkg::WALK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dda_pkg::WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_ff     <= major_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
      cnt_ff       <= cnt_in;
      dm_ff        <= dm_in;
      den_ff       <= den_in;
      dir_neg_ff   <= dir_neg_in;
      xmajor_ff    <= xmajor_in;
      color_ff     <= color_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_pixel    = out_last_ff;
   assign status.idle       = (state_ff == dda_pkg::WALK_IDLE);
   assign status.pend_valid = pend_valid_ff;

endmodule

// File: hw/rtl/dda_line_rasterizer.sv
// ============================================================================
// dda_line_rasterizer
// Clipped line rasterizer: one line item in, one item per visible pixel out.
// ============================================================================
//
//   channel  dir  handshake           payload
//   req      in   req_valid/ready     start_x, start_y, end_x, end_y, pen_color
//   rsp      out  rsp_valid/ready     pixel_x, pixel_y, pixel_color, last_pixel
//
// A line of L major-axis steps keeps the walker busy through one load, one
// step per pixel position and one flush of the held pixel, all in the
// walker's single step loop; a stalled output can hold the walker longer.
// Zero-length lines are accepted and dropped and never reach the walker.
// Up to QUEUE_DEPTH classified lines wait between the front end and walker.
// Reset is synchronous and clears the queue and all valids.
// A stalled output holds the walker only when a visible pixel is due while one is held, or at the flush.
//
// The minor coordinate uses an exact floor quotient and remainder, stepped
// by the minor delta each pixel; truncation toward zero is recovered by
// adding one when the quotient is negative and the remainder nonzero.
// The last visible pixel is known only at the end of the walk, so hold one
// pixel back and flag it when the walk finishes.
module dda_line_rasterizer #(
   parameter int CLIP_MAX    = dda_pkg::CLIP_MAX_DEFAULT,    // 1..63
   parameter int QUEUE_DEPTH = dda_pkg::QUEUE_DEPTH_DEFAULT  // 2..16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_start_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_start_y,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_end_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_end_y,
   input  logic [dda_pkg::COLOR_W-1:0]           req_pen_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dda_pkg::PIX_W-1:0]             rsp_pixel_x,
   output logic [dda_pkg::PIX_W-1:0]             rsp_pixel_y,
   output logic [dda_pkg::COLOR_W-1:0]           rsp_pixel_color,
   output logic                                  rsp_last_pixel
);

   logic                          push, pop;
   dda_pkg::dda_line_type         push_data, pop_data;
   dda_pkg::dda_queue_status_type q_status;
   dda_pkg::dda_walk_status_type  w_status;

   // classify and drop zero-length lines
   dda_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_pen_color (req_pen_color),
      .queue_full    (q_status.full),
      .push          (push),
      .push_data     (push_data)
   );

   // decouple intake from the walk
   dda_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // walk, clip and emit pixels
   dda_walk #(
      .CLIP_MAX (CLIP_MAX)
   ) u_walk (
      .clock           (clock),
      .reset           (reset),
      .line_valid      (!q_status.empty),
      .line_data       (pop_data),
      .line_pop        (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .status          (w_status)
   );

   // an idle walker never holds a pixel back
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      w_status.idle |-> !w_status.pend_valid)
      else $error("walker idle with a held pixel");

   // a full queue must stall the input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_ready)
      else $error("input ready while line queue full");

   // a pop only happens from a nonempty queue into an idle walker
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (w_status.idle && !q_status.empty))
      else $error("line popped while walker busy or queue empty");

   // an accepted line with nonzero length and no pop lands in the queue next cycle
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_status.count == $past(q_status.count) + 5'd1))
      else $error("queue count did not grow on push");

endmodule

// File: sim/dda_line_checker.sv
// ----------------------------------------------------------------------------
// dda_line_checker
// Watches both channels of the line rasterizer, predicts the pixels of each
// accepted line and compares every pixel item against the oldest prediction.
// ----------------------------------------------------------------------------
module dda_line_checker #(
   parameter int CLIP_MAX = dda_pkg::CLIP_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_start_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_start_y,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_end_x,
   input  logic signed [dda_pkg::COORD_IN_W-1:0] req_end_y,
   input  logic [dda_pkg::COLOR_W-1:0]           req_pen_color,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [dda_pkg::PIX_W-1:0]             rsp_pixel_x,
   input  logic [dda_pkg::PIX_W-1:0]             rsp_pixel_y,
   input  logic [dda_pkg::COLOR_W-1:0]           rsp_pixel_color,
   input  logic                                  rsp_last_pixel,
   output int                                    mismatch_count,
   output int                                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [dda_pkg::PIX_W-1:0]   pixel_x;
      logic [dda_pkg::PIX_W-1:0]   pixel_y;
      logic [dda_pkg::COLOR_W-1:0] color;
      logic                        last;
   } pixel_type;

   pixel_type pending_pixels[$];

   // Division in SystemVerilog truncates toward zero, as the block must.
   function automatic int minor_coord(int base, int delta, int idx, int den);
      int num;
      num = base * den + delta * idx;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      return num / den;
   endfunction

   // Walk the major axis, keep the visible pixels, flag the final one.
   function automatic void rasterize_line(int x0, int y0, int x1, int y1,
                                          logic [dda_pkg::COLOR_W-1:0] color);
      int        dx;
      int        dy;
      int        len;
      int        dir;
      int        idx;
      int        px;
      int        py;
      bit        xmajor;
      bit        have_held;
      pixel_type held;
      dx        = x1 - x0;
      dy        = y1 - y0;
      xmajor    = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy);
      len       = xmajor ? ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
      dir       = xmajor ? ((dx < 0) ? -1 : 1) : ((dy < 0) ? -1 : 1);
      have_held = 1'b0;
      held      = '0;
      for (int k = 0; k < len; k++) begin
         idx = k * dir;
         if (xmajor) begin
            px = x0 + idx;
            py = minor_coord(y0, dy, idx, dx);
         end else begin
            py = y0 + idx;
            px = minor_coord(x0, dx, idx, dy);
         end
         if (px >= 0 && py >= 0 && px <= CLIP_MAX && py <= CLIP_MAX) begin
            if (have_held) pending_pixels.push_back(held);
            held.pixel_x = px[dda_pkg::PIX_W-1:0];
            held.pixel_y = py[dda_pkg::PIX_W-1:0];
            held.color   = color;
            held.last    = 1'b0;
            have_held    = 1'b1;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         pending_pixels.push_back(held);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            rasterize_line(req_start_x, req_start_y, req_end_x, req_end_y,
                           req_pen_color);
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected pixel x=%0d y=%0d color=%h last=%b",
                           rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                           rsp_last_pixel);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_x !== want.pixel_x || rsp_pixel_y !== want.pixel_y ||
                   rsp_pixel_color !== want.color || rsp_last_pixel !== want.last)
               begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%b, %s",
                              want.pixel_x, want.pixel_y, want.color, want.last,
                              $sformatf("got x=%0d y=%0d color=%h last=%b",
                                        rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                                        rsp_last_pixel));
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = pending_pixels.size();
   end

endmodule

// File: sim/tb_dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Drives line items into the rasterizer under several idling phases: first
// directed lines (extremes, octants, clipping, zero length, truncation of
// negative sums), then random lines mostly aimed at the visible window.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLIP_MAX      = dda_pkg::CLIP_MAX_DEFAULT;
   localparam int RANDOM_LINES  = 190;
   localparam int PHASES        = 4;
   // A line holds the walker for its whole walk and two more may sit queued.
   localparam int DRAIN_CYCLES  = 1000;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic signed [dda_pkg::COORD_IN_W-1:0] req_start_x;
   logic signed [dda_pkg::COORD_IN_W-1:0] req_start_y;
   logic signed [dda_pkg::COORD_IN_W-1:0] req_end_x;
   logic signed [dda_pkg::COORD_IN_W-1:0] req_end_y;
   logic [dda_pkg::COLOR_W-1:0]           req_pen_color;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [dda_pkg::PIX_W-1:0]             rsp_pixel_x;
   logic [dda_pkg::PIX_W-1:0]             rsp_pixel_y;
   logic [dda_pkg::COLOR_W-1:0]           rsp_pixel_color;
   logic                                  rsp_last_pixel;

   int mismatch_count;
   int pending_count;
   int cycle_count;
   int send_idle_pct;   // chance per cycle that the sender holds off
   int rsp_stall_pct;   // chance per cycle that the receiver stalls

   dda_line_rasterizer #(
      .CLIP_MAX (CLIP_MAX)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_pen_color   (req_pen_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   dda_line_checker #(
      .CLIP_MAX (CLIP_MAX)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_pen_color   (req_pen_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run; the limit is many times the slowest correct run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dda_line_rasterizer test failed");
         $finish;
      end
   end

   // Stall the pixel channel at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offer one line item: idle first at the phase rate, then hold valid and
   // payload until accepted. Valid stays high on return so that a following
   // item in the same cycle takes only one assignment.
   task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [dda_pkg::COLOR_W-1:0] color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_x   <= sx[dda_pkg::COORD_IN_W-1:0];
      req_start_y   <= sy[dda_pkg::COORD_IN_W-1:0];
      req_end_x     <= ex[dda_pkg::COORD_IN_W-1:0];
      req_end_y     <= ey[dda_pkg::COORD_IN_W-1:0];
      req_pen_color <= color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Pick a coordinate: mostly around the visible window, sometimes anywhere.
   function automatic int pick_coord(bit near_window);
      if (near_window) return $urandom_range(CLIP_MAX + 16) - 16;
      return int'($urandom_range(255)) - 128;
   endfunction

   initial begin
      int sx;
      int sy;
      int ex;
      int ey;
      int choice;
      bit near_window;

      // Drive every input to a known value before the first edge.
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_start_x   <= '0;
      req_start_y   <= '0;
      req_end_x     <= '0;
      req_end_y     <= '0;
      req_pen_color <= '0;
      rsp_ready     <= 1'b0;
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, no idling.
      send_line(10, 10, 10, 10, 32'h1234_5678);           // zero length
      send_line(0, 0, 63, 0, 32'h0000_0000);              // visible row, end point excluded
      send_line(63, 63, 0, 0, 32'hFFFF_FFFF);             // reversed diagonal
      send_line(0, 0, 0, 63, 32'hAAAA_AAAA);              // visible column, end point excluded
      send_line(-128, -128, 127, 127, 32'h5555_5555);     // extreme diagonal
      send_line(127, -128, -128, 127, 32'hFFFF_FFFF);
      send_line(-128, 127, 127, -128, 32'h0000_0000);
      send_line(100, 100, 120, 90, $urandom);             // fully clipped
      send_line(-10, -10, -1, -50, $urandom);             // fully clipped
      send_line(0, -1, 10, 1, $urandom);                  // negative sum truncates to 0
      send_line(-1, 0, 1, 10, $urandom);                  // same, vertical major
      send_line(40, 5, 2, 60, $urandom);                  // steep, x falling
      send_line(5, 40, 60, 2, $urandom);                  // shallow, y falling
      send_line(30, 30, 31, 30, $urandom);                // single pixel
      send_line(30, 30, 29, 29, $urandom);                // single pixel, backward
      send_line(0, 0, -128, 127, $urandom);               // mostly clipped
      send_line(63, 0, 64, 0, $urandom);                  // pixel on the clip edge
      send_line(64, 64, 63, 63, $urandom);                // start just outside
      send_line(0, 63, 127, -1, $urandom);
      send_line(-128, 32, 127, 32, $urandom);             // longest horizontal
      send_line(32, -128, 32, 127, $urandom);             // longest vertical
      send_line(20, 50, 22, -70, $urandom);               // near-vertical through window

      // Random lines across the idling phases.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct <= 53; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  rsp_stall_pct <= 53; end
            default: begin send_idle_pct <= 17; rsp_stall_pct <= 17; end
         endcase
         for (int n = 0; n < RANDOM_LINES / PHASES; n++) begin
            choice      = $urandom_range(99);
            near_window = (choice < 75);
            sx = pick_coord(near_window);
            sy = pick_coord(near_window);
            // Keep a few short lines and zero-length ones in the mix.
            if (choice >= 90) begin
               ex = sx + int'($urandom_range(6)) - 3;
               ey = sy + int'($urandom_range(6)) - 3;
               if (ex > 127) ex = 127;
               if (ex < -128) ex = -128;
               if (ey > 127) ey = 127;
               if (ey < -128) ey = -128;
            end else begin
               ex = pick_coord(near_window);
               ey = pick_coord(near_window);
            end
            send_line(sx, sy, ex, ey, $urandom);
         end
      end
      req_valid <= 1'b0;
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;

      // Let the checker see the last item, drain, then wait out the walker.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("dda_line_rasterizer test passed");
      end else begin
         $display("dda_line_rasterizer test failed");
      end
      $finish;
   end

endmodule
